>>> rtl/core/bkr_pkg.sv
package bkr_pkg;

	localparam int CODE_W      = 64;
	localparam int MAX_BASES   = CODE_W / 2;
	localparam int LEN_W       = 6;
	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ORIENTATION = 1'b1;

	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_C       = 8'h43;
	localparam logic [7:0] CHAR_G       = 8'h47;
	localparam logic [7:0] CHAR_T       = 8'h54;
	localparam logic [7:0] CHAR_Z       = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_OPEN    = 8'h28;
	localparam logic [7:0] CHAR_CLOSE   = 8'h29;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_BASE  = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_OVERFLOW  = 3'd3,
		ERR_UNCLOSED  = 3'd4
	} bkr_err_t;

	// Reverses the order of all base slots and complements each base.
	function automatic logic [CODE_W-1:0] rev_comp_full(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_BASES; i++) begin
			r[2*(MAX_BASES-1-i) +: 2] = ~code[2*i +: 2];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/bracketed_kmer_roller.sv
// Rolling 2-bit k-mer encoder for bracketed DNA tokens.
// Input channel: one character per transfer on sym_valid/sym_stall with
// symbol, token_first and token_last. Output channel: kmer_valid/kmer_stall
// with kmer_code, error_code and token_end. A character that neither
// completes a k-mer nor raises an error produces no output transfer.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 kmer_length,
// 1 keep_orientation) and cfg_data; cfg_ready is always high, and writes
// must be made only while the block is idle; it does not enforce this.
// A character is registered in the input stage on its input transfer and is
// processed from there; its result, if any, is registered in the output stage.
// One character is taken every cycle as long as the output is not stalled.
// The bracket stack keeps its top entry in a register and the rest in a
// memory whose registered read port always prefetches the entry below the
// top, so a push or pop never waits for a memory read.
// Reset clears the token state and sets kmer_length to 31 and
// keep_orientation to 0; no stack clearing pass is needed.
// While the output is stalled the result holds, the input stage holds one
// further character, and sym_stall rises once that stage is full.
module bracketed_kmer_roller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  logic [7:0]                    symbol,
	input  logic                          token_first,
	input  logic                          token_last,
	output logic                          kmer_valid,
	input  logic                          kmer_stall,
	output logic [bkr_pkg::CODE_W-1:0]    kmer_code,
	output logic [2:0]                    error_code,
	output logic                          token_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bkr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bkr_pkg::LEN_W-1:0]     cfg_data
);
	import bkr_pkg::*;

	logic                valid_s1;
	logic [7:0]          symbol_s1;
	logic                first_s1;
	logic                last_s1;

	logic [LEN_W-1:0]    kmer_len_q;
	logic                keep_q;
	logic [CODE_W-1:0]   code_q;
	logic [LEN_W-1:0]    loaded_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                dead_q;
	logic [CODE_W-1:0]   top_q;
	logic [CODE_W-1:0]   below_q;
	logic [CODE_W-1:0]   stack_mem [STACK_DEPTH];

	logic                out_valid_q;
	logic [CODE_W-1:0]   kmer_q;
	bkr_err_t            err_q;
	logic                end_q;

	logic                advance;
	logic                upd;
	logic [LEN_W-1:0]    k_eff;
	logic [6:0]          shamt;
	logic [CODE_W-1:0]   mask;
	logic [7:0]          ch;
	logic [CODE_W-1:0]   cur;
	logic [LEN_W-1:0]    ld;
	logic [DEPTH_W-1:0]  dp;
	logic                dead;
	logic [1:0]          g;
	logic                bad_base;
	logic                base_emit;
	logic                push_wr;
	logic [CODE_W-1:0]   nxt_code;
	logic [LEN_W-1:0]    nxt_loaded;
	logic [DEPTH_W-1:0]  nxt_depth;
	logic [CODE_W-1:0]   nxt_top;
	logic [CODE_W-1:0]   rc;
	logic [CODE_W-1:0]   kmer;
	bkr_err_t            err;
	logic                emit;
	logic [DEPTH_W-1:0]  depth_after;
	logic [DEPTH_W-1:0]  raddr_full;
	logic [DEPTH_W-1:0]  waddr_full;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && !(out_valid_q && kmer_stall);
	assign sym_stall  = valid_s1 && !advance;
	assign kmer_valid = out_valid_q;
	assign kmer_code  = kmer_q;
	assign error_code = err_q;
	assign token_end  = end_q;

	always_comb begin
		if (kmer_len_q == '0) begin
			k_eff = LEN_W'(1);
		end else if (kmer_len_q > LEN_W'(MAX_BASES)) begin
			k_eff = LEN_W'(MAX_BASES);
		end else begin
			k_eff = kmer_len_q;
		end
	end

	assign shamt = 7'(CODE_W) - {k_eff, 1'b0};
	assign mask  = {CODE_W{1'b1}} >> shamt;

	always_comb begin
		cur  = first_s1 ? '0 : code_q;
		ld   = first_s1 ? '0 : loaded_q;
		dp   = first_s1 ? '0 : depth_q;
		dead = first_s1 ? 1'b0 : dead_q;

		ch = symbol_s1;
		if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
			ch = ch - CASE_OFFSET;
		end

		g          = BASE_A;
		bad_base   = 1'b0;
		base_emit  = 1'b0;
		push_wr    = 1'b0;
		nxt_code   = cur;
		nxt_loaded = ld;
		nxt_depth  = dp;
		nxt_top    = top_q;
		err        = ERR_NONE;

		if (ch == CHAR_OPEN) begin
			if (dp == DEPTH_W'(STACK_DEPTH)) begin
				err = ERR_OVERFLOW;
			end else begin
				push_wr   = (dp != '0);
				nxt_top   = cur;
				nxt_depth = dp + DEPTH_W'(1);
			end
		end else if (ch == CHAR_CLOSE) begin
			if (dp == '0) begin
				err = ERR_UNDERFLOW;
			end else begin
				nxt_code  = top_q;
				nxt_top   = below_q;
				nxt_depth = dp - DEPTH_W'(1);
			end
		end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
			case (ch)
				CHAR_A: g = BASE_A;
				CHAR_C: g = BASE_C;
				CHAR_G: g = BASE_G;
				CHAR_T: g = BASE_T;
				default: bad_base = 1'b1;
			endcase
			if (bad_base) begin
				err = ERR_BAD_BASE;
			end else begin
				nxt_code   = {cur[CODE_W-3:0], g} & mask;
				nxt_loaded = (ld == {LEN_W{1'b1}}) ? ld : ld + LEN_W'(1);
				base_emit  = (nxt_loaded >= k_eff);
			end
		end

		rc = rev_comp_full(nxt_code) >> shamt;
		if (!base_emit) begin
			kmer = '0;
		end else if (keep_q || nxt_code <= rc) begin
			kmer = nxt_code;
		end else begin
			kmer = rc;
		end

		if (err == ERR_NONE && last_s1 && nxt_depth != '0) begin
			err = ERR_UNCLOSED;
		end
		emit = !dead && (base_emit || err != ERR_NONE);
	end

	assign upd         = advance && !dead;
	assign depth_after = upd ? nxt_depth : depth_q;
	assign raddr_full  = depth_after - DEPTH_W'(2);
	assign waddr_full  = depth_q - DEPTH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			kmer_len_q  <= LEN_W'(31);
			keep_q      <= 1'b0;
			code_q      <= '0;
			loaded_q    <= '0;
			depth_q     <= '0;
			dead_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sym_valid && !sym_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KMER_LENGTH:      kmer_len_q <= cfg_data;
					CFG_KEEP_ORIENTATION: keep_q     <= cfg_data[0];
					default: ;
				endcase
			end

			if (upd) begin
				code_q   <= nxt_code;
				loaded_q <= nxt_loaded;
				depth_q  <= nxt_depth;
				dead_q   <= (err != ERR_NONE);
			end

			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!kmer_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_valid && !sym_stall) begin
			symbol_s1 <= symbol;
			first_s1  <= token_first;
			last_s1   <= token_last;
		end
		if (upd) begin
			top_q <= nxt_top;
		end
		if (advance && emit) begin
			kmer_q <= kmer;
			err_q  <= err;
			end_q  <= (err != ERR_NONE) || last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && push_wr) begin
			stack_mem[waddr_full[STACK_AW-1:0]] <= top_q;
			below_q <= top_q;
		end else begin
			below_q <= stack_mem[raddr_full[STACK_AW-1:0]];
		end
	end

endmodule

>>> rtl/core/bkr_checker.sv
module bkr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sym_valid,
	input logic                          sym_stall,
	input logic                          kmer_valid,
	input logic                          kmer_stall,
	input logic [bkr_pkg::CODE_W-1:0]    kmer_code,
	input logic [2:0]                    error_code,
	input logic                          token_end
);
	import bkr_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kmer_valid && kmer_stall |=> kmer_valid && $stable(kmer_code)
			&& $stable(error_code) && $stable(token_end))
		else $error("result changed while stalled");

	// Every error closes the token.
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		kmer_valid && error_code != ERR_NONE |-> token_end)
		else $error("error result without token end");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		kmer_valid |-> error_code <= ERR_UNCLOSED)
		else $error("error code out of range");

	// A fresh result follows an input transfer that passed through the input stage.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(kmer_valid) |-> $past(sym_valid && !sym_stall, 2))
		else $error("result without a preceding input transfer");

endmodule

bind bracketed_kmer_roller bkr_checker u_bkr_checker (.*);
